/* rtl/core/dtq_pkg.sv */
`default_nettype none
package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic [15:0] cd;
    logic [7:0]  sender;
    logic [7:0]  tag;
    logic [15:0] handle;
  } entry_t;

  typedef struct packed {
    logic load;
    logic dec;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic             load;
    logic             dec;
    logic             shift;
    logic [OCC_W-1:0] load_idx;
  } chain_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_REL
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/delay_timer_queue.sv */
// Delay-request timer queue.
// Input channel (in_valid/in_ready) carries one word per item: in_kind 0
// appends a delay request (in_delay_ticks, in_sender, in_tag, in_handle),
// in_kind 1 is one timer tick. Result channel (out_valid/out_ready) returns
// words with out_last marking the final word of an item.
// A request returns one word, out_status 1 when the
// queue was full and the request was dropped.
// A tick first decrements every countdown, then releases the expired
// entries at the head one word each (1 to QUEUE_DEPTH words), since each
// release shifts the cell chain by one place toward the head. A tick that
// releases nothing returns one word with out_released 0.
// One item is in work at a time; a new item is taken once the previous one
// has handed its last word to the output register.
// The output register holds a word until out_ready; a stalled receiver
// stalls release and input acceptance, nothing is lost.
// Reset empties the queue and clears the tick counter; no clearing pass.
`default_nettype none
module delay_timer_queue
  import dtq_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_kind,
  input  wire  [15:0] in_delay_ticks,
  input  wire  [7:0]  in_sender,
  input  wire  [7:0]  in_tag,
  input  wire  [15:0] in_handle,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_released,
  output logic [7:0]  out_sender,
  output logic [7:0]  out_tag,
  output logic [15:0] out_handle,
  output logic        out_status,
  output logic [31:0] out_ticks_elapsed,
  output logic        out_last
);

  state_t            state_r, state_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [31:0]       tick_r, tick_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              rel_r, status_r, last_r;
  logic [7:0]        sender_r, tag_r;
  logic [15:0]       handle_r;
  logic [31:0]       ticks_r;

  chain_ctl_t        cctl;
  entry_t            load_data, head, second;

  logic out_free, accept, is_req, full, head_rel, next_rel, rel_fire, out_load;
  logic load_rel, load_status, load_last;
  entry_t load_ent;

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_req   = (in_kind == KIND_REQ);
  assign full     = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign head_rel = (occ_r != '0) && (head.cd == 16'd0);
  assign next_rel = (occ_r > OCC_W'(1)) && (second.cd == 16'd0);
  assign rel_fire = (state_r == ST_REL) && out_free;

  always_comb begin
    load_data.cd     = in_delay_ticks;
    load_data.sender = in_sender;
    load_data.tag    = in_tag;
    load_data.handle = in_handle;
  end

  dtq_chain u_chain (
    .clk       (clk),
    .ctl       (cctl),
    .load_data (load_data),
    .head      (head),
    .second    (second)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_kind == KIND_TICK) begin
          state_nxt = ST_REL;
        end
      end
      ST_REL: begin
        if (rel_fire && !(head_rel && next_rel)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE) && out_free;
    cctl.load     = accept && is_req && !full;
    cctl.dec      = accept && !is_req;
    cctl.shift    = rel_fire && head_rel;
    cctl.load_idx = occ_r;
    out_load      = (accept && is_req) || rel_fire;
    load_ent      = '0;
    load_rel      = 1'b0;
    load_status   = 1'b0;
    load_last     = 1'b1;
    if (state_r == ST_REL) begin
      load_rel  = head_rel;
      load_last = !(head_rel && next_rel);
      if (head_rel) begin
        load_ent = head;
      end
    end else begin
      load_status = full;
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (cctl.load) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (cctl.shift) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
    tick_nxt = cctl.dec ? tick_r + 32'd1 : tick_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rel_r    <= load_rel;
      sender_r <= load_ent.sender;
      tag_r    <= load_ent.tag;
      handle_r <= load_ent.handle;
      status_r <= load_status;
      ticks_r  <= tick_r;
      last_r   <= load_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_released      = rel_r;
  assign out_sender        = sender_r;
  assign out_tag           = tag_r;
  assign out_handle        = handle_r;
  assign out_status        = status_r;
  assign out_ticks_elapsed = ticks_r;
  assign out_last          = last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_rel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_released |-> !out_status)
    else $error("released word flagged as dropped");

  a_shift_occ: assert property (@(posedge clk) disable iff (!rst_n)
    cctl.shift |=> occ_r == $past(occ_r) - OCC_W'(1))
    else $error("release did not drop occupancy");

  a_tick_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_kind == KIND_TICK |=> tick_r == $past(tick_r) + 32'd1 && state_r == ST_REL)
    else $error("tick not counted");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE && !cctl.shift)
    else $error("input taken during release");

endmodule
`default_nettype wire

/* rtl/core/dtq_cell.sv */
`default_nettype none
module dtq_cell
  import dtq_pkg::*;
(
  input  wire        clk,
  input  cell_ctl_t  ctl,
  input  entry_t     load_data,
  input  entry_t     nbr,
  output entry_t     ent
);

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift) begin
      entry_nxt = nbr;
    end else if (ctl.load) begin
      entry_nxt = load_data;
    end else if (ctl.dec && entry_r.cd != 16'd0) begin
      entry_nxt.cd = entry_r.cd - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign ent = entry_r;

endmodule
`default_nettype wire

/* rtl/core/dtq_chain.sv */
`default_nettype none
module dtq_chain
  import dtq_pkg::*;
(
  input  wire        clk,
  input  chain_ctl_t ctl,
  input  entry_t     load_data,
  output entry_t     head,
  output entry_t     second
);

  entry_t ents [QUEUE_DEPTH+1];

  assign ents[QUEUE_DEPTH] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      cell_ctl_t cctl;

      always_comb begin
        cctl.load  = ctl.load && (ctl.load_idx == OCC_W'(gi));
        cctl.dec   = ctl.dec;
        cctl.shift = ctl.shift;
      end

      dtq_cell u_cell (
        .clk       (clk),
        .ctl       (cctl),
        .load_data (load_data),
        .nbr       (ents[gi+1]),
        .ent       (ents[gi])
      );
    end
  endgenerate

  assign head   = ents[0];
  assign second = ents[1];

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps

typedef struct packed {
  logic        released;
  logic [7:0]  sender;
  logic [7:0]  tag;
  logic [15:0] handle;
  logic        status;
  logic [31:0] ticks;
  logic        last;
} timer_word_t;

class timer_queue_scoreboard;
  dtq_pkg::entry_t queue_slots[dtq_pkg::QUEUE_DEPTH];
  int unsigned     queue_fill;
  logic [31:0]     tick_count;
  timer_word_t     due_words[$];
  int unsigned     items_seen;
  int unsigned     ticks_seen;
  int unsigned     words_seen;
  int unsigned     releases;
  int unsigned     drops;
  int unsigned     widest_burst;
  int unsigned     errors;

  function new();
    queue_fill   = 0;
    tick_count   = '0;
    items_seen   = 0;
    ticks_seen   = 0;
    words_seen   = 0;
    releases     = 0;
    drops        = 0;
    widest_burst = 0;
    errors       = 0;
  endfunction

  function void flag(string what);
    errors++;
    if (errors <= 10) begin
      $display("%s", what);
    end
  endfunction

  function void note_item(logic kind, logic [15:0] req_delay, logic [7:0] req_sender,
                          logic [7:0] req_tag, logic [15:0] req_handle);
    timer_word_t w;
    int unsigned burst;
    int          i;
    items_seen++;
    w = '0;
    if (kind == dtq_pkg::KIND_REQ) begin
      if (queue_fill >= dtq_pkg::QUEUE_DEPTH) begin
        w.status = 1'b1;
        drops++;
      end else begin
        queue_slots[queue_fill] = '{cd: req_delay, sender: req_sender, tag: req_tag,
                                    handle: req_handle};
        queue_fill++;
      end
      w.ticks = tick_count;
      w.last  = 1'b1;
      due_words.push_back(w);
      return;
    end
    ticks_seen++;
    tick_count = tick_count + 32'd1;
    for (i = 0; i < queue_fill; i++) begin
      if (queue_slots[i].cd != 16'd0) begin
        queue_slots[i].cd = queue_slots[i].cd - 16'd1;
      end
    end
    burst = 0;
    while (queue_fill > 0 && queue_slots[0].cd == 16'd0) begin
      w          = '0;
      w.released = 1'b1;
      w.sender   = queue_slots[0].sender;
      w.tag      = queue_slots[0].tag;
      w.handle   = queue_slots[0].handle;
      w.ticks    = tick_count;
      due_words.push_back(w);
      for (i = 1; i < queue_fill; i++) begin
        queue_slots[i - 1] = queue_slots[i];
      end
      queue_fill--;
      burst++;
    end
    if (burst == 0) begin
      w       = '0;
      w.ticks = tick_count;
      w.last  = 1'b1;
      due_words.push_back(w);
    end else begin
      due_words[due_words.size() - 1].last = 1'b1;
      releases += burst;
      if (burst > widest_burst) begin
        widest_burst = burst;
      end
    end
  endfunction

  function void check_word(timer_word_t got);
    timer_word_t want;
    words_seen++;
    if (due_words.size() == 0) begin
      flag($sformatf("word %0d arrived with nothing due: rel=%0b snd=%h tag=%h hnd=%h st=%0b ticks=%0d last=%0b",
                     words_seen, got.released, got.sender, got.tag, got.handle, got.status,
                     got.ticks, got.last));
      return;
    end
    want = due_words.pop_front();
    if (got.released !== want.released || got.sender !== want.sender ||
        got.tag !== want.tag || got.handle !== want.handle ||
        got.status !== want.status || got.ticks !== want.ticks ||
        got.last !== want.last) begin
      flag($sformatf({"word %0d mismatch: expected rel=%0b snd=%h tag=%h hnd=%h st=%0b",
                      " ticks=%0d last=%0b, got rel=%0b snd=%h tag=%h hnd=%h st=%0b",
                      " ticks=%0d last=%0b"},
                     words_seen, want.released, want.sender, want.tag, want.handle,
                     want.status, want.ticks, want.last, got.released, got.sender, got.tag,
                     got.handle, got.status, got.ticks, got.last));
    end
  endfunction
endclass

module testbench;
  import dtq_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = KIND_REQ;
  logic [15:0] in_delay_ticks = '0;
  logic [7:0]  in_sender = '0;
  logic [7:0]  in_tag = '0;
  logic [15:0] in_handle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_released;
  logic [7:0]  out_sender;
  logic [7:0]  out_tag;
  logic [15:0] out_handle;
  logic        out_status;
  logic [31:0] out_ticks_elapsed;
  logic        out_last;

  int unsigned idle_cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned hold_left = 0;

  timer_queue_scoreboard ledger = new();

  always #4 clk = ~clk;

  delay_timer_queue i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_delay_ticks    (in_delay_ticks),
    .in_sender         (in_sender),
    .in_tag            (in_tag),
    .in_handle         (in_handle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_released      (out_released),
    .out_sender        (out_sender),
    .out_tag           (out_tag),
    .out_handle        (out_handle),
    .out_status        (out_status),
    .out_ticks_elapsed (out_ticks_elapsed),
    .out_last          (out_last)
  );

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      ledger.note_item(in_kind, in_delay_ticks, in_sender, in_tag, in_handle);
    end
    if (rst_n && out_valid && out_ready) begin
      ledger.check_word(timer_word_t'{released: out_released, sender: out_sender,
                                      tag: out_tag, handle: out_handle, status: out_status,
                                      ticks: out_ticks_elapsed, last: out_last});
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 16'($urandom_range(0, 6));
    end
    if (r < 98) begin
      return 16'($urandom_range(7, 40));
    end
    return 16'($urandom_range(41, 120));
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = 1'b1;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        hold_left = gap_len();
      end
    end
  end

  task automatic send_item(logic kind, logic [15:0] delay, logic [7:0] sender,
                           logic [7:0] tag, logic [15:0] handle);
    int unsigned pause;
    @(negedge clk);
    in_valid       = 1'b1;
    in_kind        = kind;
    in_delay_ticks = delay;
    in_sender      = sender;
    in_tag         = tag;
    in_handle      = handle;
    do @(posedge clk); while (!in_ready);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      pause = gap_len();
      @(negedge clk);
      in_valid = 1'b0;
      repeat (pause - 1) @(negedge clk);
    end
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic send_request(logic [15:0] delay);
    send_item(KIND_REQ, delay, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // hold the sender until every due word is back
  task automatic wait_all_words();
    @(negedge clk);
    in_valid = 1'b0;
    while (ledger.due_words.size() != 0) @(negedge clk);
  endtask

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned tick_pct[4];
    int unsigned idle_pct[4];
    int          p;
    int          n;
    tick_pct = '{25, 45, 60, 35};
    idle_pct = '{30, 0, 50, 15};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    gap_pct = 20;
    send_tick();
    send_item(KIND_REQ, 16'h0000, 8'h00, 8'h00, 16'h0000);
    send_item(KIND_REQ, 16'h0001, 8'hFF, 8'hFF, 16'hFFFF);
    send_tick();
    // expired entry waits behind a live head
    send_request(16'd2);
    send_request(16'd0);
    send_tick();
    send_tick();
    send_item(KIND_REQ, 16'd30, 8'h5A, 8'hA5, 16'h3CC3);
    for (n = 1; n < QUEUE_DEPTH; n++) begin
      send_request(16'($urandom_range(0, 4)));
    end
    send_request(16'($urandom));
    wait_all_words();

    // run the head down to zero, then the whole queue drains in one burst
    gap_pct = 0;
    repeat (30) send_tick();
    wait_all_words();

    for (p = 0; p < 4; p++) begin
      gap_pct = idle_pct[p];
      for (n = 0; n < 40; n++) begin
        if ($urandom_range(0, 99) < tick_pct[p]) begin
          send_tick();
        end else begin
          send_request(pick_delay());
        end
      end
      wait_all_words();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (ledger.due_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run: %0d items (%0d ticks), %0d words checked, %0d entries released",
             ledger.items_seen, ledger.ticks_seen, ledger.words_seen, ledger.releases);
    $display("     %0d requests dropped on a full queue, largest release burst %0d, %0d errors",
             ledger.drops, ledger.widest_burst, ledger.errors);
    if (ledger.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
